// ===== design/bbes_pkg.sv =====
// ----------------------------------------------------------------------------
// Box best edge select package
// Shared widths, types and latency figures for the best edge selection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bbes_pkg;

	localparam int COORD_W    = 32;
	localparam int NORM_W     = 16;
	localparam int UNIT_W     = 16;
	localparam int MAG_W      = 31;
	localparam int FRAC_W     = 14;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 15;
	localparam int SIDE_LAT   = 2 + SQRT_STEPS + DIV_STEPS + 1;
	localparam int FRONT_LAT  = 7;
	localparam int BACK_LAT   = 3;
	localparam int TOTAL_LAT  = FRONT_LAT + SIDE_LAT + BACK_LAT;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [NORM_W-1:0]  norm_t;
	typedef logic signed [UNIT_W-1:0]  unit_t;
	typedef logic [MAG_W-1:0]          mag_t;
	typedef logic [1:0]                cidx_t;

	typedef struct packed {
		norm_t  nx;
		norm_t  ny;
		cidx_t  idx;
		coord_t deep_x;
		coord_t deep_y;
		coord_t prev_x;
		coord_t prev_y;
		coord_t next_x;
		coord_t next_y;
	} carry_t;

	typedef struct packed {
		mag_t mx;
		mag_t my;
		logic negx;
		logic negy;
	} side_in_t;

endpackage

`default_nettype wire

// ===== design/bbes_side_unit.sv =====
// ----------------------------------------------------------------------------
// Box best edge select side unit
// Pipelined unit vector of one side: squares, integer square root, division.
// ----------------------------------------------------------------------------
`default_nettype none

module bbes_side_unit (
	input  wire                    clk,
	input  wire bbes_pkg::side_in_t side,
	output bbes_pkg::unit_t        ux,
	output bbes_pkg::unit_t        uy
);
	import bbes_pkg::*;

	localparam int REM_W = MAG_W + FRAC_W + 1;

	side_in_t    sd_s1;
	logic [61:0] sqx_s1, sqy_s1;
	side_in_t    sd_s2;

	logic [63:0] sq_rem [0:SQRT_STEPS];
	logic [63:0] sq_res [0:SQRT_STEPS];
	side_in_t    sq_sd  [0:SQRT_STEPS];

	logic [REM_W-1:0]     dv_rx  [0:DIV_STEPS];
	logic [REM_W-1:0]     dv_ry  [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] dv_qx  [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] dv_qy  [0:DIV_STEPS];
	logic [COORD_W-1:0]   dv_len [0:DIV_STEPS];
	logic                 dv_nx  [0:DIV_STEPS];
	logic                 dv_ny  [0:DIV_STEPS];

	always_ff @(posedge clk) begin
		sd_s1     <= side;
		sqx_s1    <= 62'(side.mx) * 62'(side.mx);
		sqy_s1    <= 62'(side.my) * 62'(side.my);
		sd_s2     <= sd_s1;
		sq_rem[0] <= 64'(sqx_s1) + 64'(sqy_s1);
	end

	assign sq_res[0] = '0;
	assign sq_sd[0]  = sd_s2;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam int I = SQRT_STEPS - 1 - k;
		logic [63:0] bitv;
		logic [63:0] tgt;
		logic        ge;
		assign bitv = 64'(1) << (2 * I);
		assign tgt  = sq_res[k] + bitv;
		assign ge   = sq_rem[k] >= tgt;
		always_ff @(posedge clk) begin
			sq_rem[k+1] <= ge ? sq_rem[k] - tgt : sq_rem[k];
			sq_res[k+1] <= ge ? (sq_res[k] >> 1) + bitv : sq_res[k] >> 1;
			sq_sd[k+1]  <= sq_sd[k];
		end
	end

	assign dv_rx[0]  = {1'b0, sq_sd[SQRT_STEPS].mx, FRAC_W'(0)};
	assign dv_ry[0]  = {1'b0, sq_sd[SQRT_STEPS].my, FRAC_W'(0)};
	assign dv_qx[0]  = '0;
	assign dv_qy[0]  = '0;
	assign dv_len[0] = sq_res[SQRT_STEPS][COORD_W-1:0];
	assign dv_nx[0]  = sq_sd[SQRT_STEPS].negx;
	assign dv_ny[0]  = sq_sd[SQRT_STEPS].negy;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int I = DIV_STEPS - 1 - k;
		logic [REM_W-1:0] dl;
		logic             gx, gy;
		assign dl = REM_W'(dv_len[k]) << I;
		assign gx = dv_rx[k] >= dl;
		assign gy = dv_ry[k] >= dl;
		always_ff @(posedge clk) begin
			dv_rx[k+1]  <= gx ? dv_rx[k] - dl : dv_rx[k];
			dv_ry[k+1]  <= gy ? dv_ry[k] - dl : dv_ry[k];
			dv_qx[k+1]  <= dv_qx[k] | (DIV_STEPS'(gx) << I);
			dv_qy[k+1]  <= dv_qy[k] | (DIV_STEPS'(gy) << I);
			dv_len[k+1] <= dv_len[k];
			dv_nx[k+1]  <= dv_nx[k];
			dv_ny[k+1]  <= dv_ny[k];
		end
	end

	logic  zero_len;
	unit_t qx, qy;
	assign zero_len = dv_len[DIV_STEPS] == '0;
	assign qx = $signed({1'b0, dv_qx[DIV_STEPS]});
	assign qy = $signed({1'b0, dv_qy[DIV_STEPS]});

	always_ff @(posedge clk) begin
		ux <= zero_len ? '0 : (dv_nx[DIV_STEPS] ? -qx : qx);
		uy <= zero_len ? '0 : (dv_ny[DIV_STEPS] ? -qy : qy);
	end

endmodule

`default_nettype wire

// ===== design/box_best_edge_select_unit.sv =====
// ----------------------------------------------------------------------------
// Box best edge select unit
// Picks the deepest box corner along a normal and the box edge best suited
// for clipping.
// ----------------------------------------------------------------------------
// A transfer is taken on every cycle in which start is high; busy is always
// low. Each transfer produces one result, marked by done for one cycle. The
// receiver cannot stall the unit, so each result must be taken in the cycle
// that done marks. Most of the latency is in the square root and divider
// pipelines of the side unit, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module box_best_edge_select_unit (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire bbes_pkg::norm_t  normal_x,
	input  wire bbes_pkg::norm_t  normal_y,
	input  wire bbes_pkg::coord_t corner0_x,
	input  wire bbes_pkg::coord_t corner0_y,
	input  wire bbes_pkg::coord_t corner1_x,
	input  wire bbes_pkg::coord_t corner1_y,
	input  wire bbes_pkg::coord_t corner2_x,
	input  wire bbes_pkg::coord_t corner2_y,
	input  wire bbes_pkg::coord_t corner3_x,
	input  wire bbes_pkg::coord_t corner3_y,
	output logic                 done,
	output bbes_pkg::cidx_t      deepest_index,
	output bbes_pkg::coord_t     deepest_x,
	output bbes_pkg::coord_t     deepest_y,
	output bbes_pkg::coord_t     edge_start_x,
	output bbes_pkg::coord_t     edge_start_y,
	output bbes_pkg::coord_t     edge_end_x,
	output bbes_pkg::coord_t     edge_end_y
);
	import bbes_pkg::*;

	logic [TOTAL_LAT-1:0] vld_q;

	norm_t  nx_s1, ny_s1, nx_s2, ny_s2, nx_s3, ny_s3, nx_s4, ny_s4, nx_s5, ny_s5;
	norm_t  nx_s6, ny_s6;
	coord_t cx_s1 [0:3], cy_s1 [0:3], cx_s2 [0:3], cy_s2 [0:3];
	coord_t cx_s3 [0:3], cy_s3 [0:3], cx_s4 [0:3], cy_s4 [0:3];
	logic signed [47:0] px_s2 [0:3], py_s2 [0:3];
	logic signed [48:0] p_s3 [0:3];
	logic signed [48:0] b01_s4, b23_s4;
	cidx_t  i01_s4, i23_s4;
	cidx_t  idx_s5, idx_s6;
	coord_t dx_s5, dy_s5, px_s5, py_s5, qx_s5, qy_s5;
	coord_t dx_s6, dy_s6, px_s6, py_s6, qx_s6, qy_s6;
	logic signed [32:0] dpx_s6, dpy_s6, dnx_s6, dny_s6;
	carry_t   cr_s7;
	side_in_t sp_s7, sn_s7;
	carry_t   cr_d [0:SIDE_LAT-1];
	unit_t    upx, upy, unx, uny;
	carry_t   cr_p1, cr_p2;
	logic signed [31:0] m_px, m_py, m_nx, m_ny;
	logic signed [32:0] dot_p, dot_n;

	cidx_t  sel, selp, seln;
	always_comb begin
		sel  = (b23_s4 > b01_s4) ? i23_s4 : i01_s4;
		selp = sel - 2'd1;
		seln = sel + 2'd1;
	end

	function automatic side_in_t reduce(input logic signed [32:0] ex,
		input logic signed [32:0] ey);
		logic [32:0] ax, ay;
		side_in_t r;
		ax = ex[32] ? 33'(-ex) : 33'(ex);
		ay = ey[32] ? 33'(-ey) : 33'(ey);
		if (ax[32] || ay[32]) begin
			ax = ax >> 2;
			ay = ay >> 2;
		end else if (ax[31] || ay[31]) begin
			ax = ax >> 1;
			ay = ay >> 1;
		end
		r.mx   = ax[MAG_W-1:0];
		r.my   = ay[MAG_W-1:0];
		r.negx = ex[32];
		r.negy = ey[32];
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		nx_s1 <= normal_x;
		ny_s1 <= normal_y;
		cx_s1[0] <= corner0_x; cy_s1[0] <= corner0_y;
		cx_s1[1] <= corner1_x; cy_s1[1] <= corner1_y;
		cx_s1[2] <= corner2_x; cy_s1[2] <= corner2_y;
		cx_s1[3] <= corner3_x; cy_s1[3] <= corner3_y;
		for (int k = 0; k < 4; k++) begin
			px_s2[k] <= nx_s1 * cx_s1[k];
			py_s2[k] <= ny_s1 * cy_s1[k];
			p_s3[k]  <= px_s2[k] + py_s2[k];
		end
		cx_s2 <= cx_s1; cy_s2 <= cy_s1; cx_s3 <= cx_s2; cy_s3 <= cy_s2;
		cx_s4 <= cx_s3; cy_s4 <= cy_s3;
		nx_s2 <= nx_s1; ny_s2 <= ny_s1; nx_s3 <= nx_s2; ny_s3 <= ny_s2;
		nx_s4 <= nx_s3; ny_s4 <= ny_s3; nx_s5 <= nx_s4; ny_s5 <= ny_s4;
		nx_s6 <= nx_s5; ny_s6 <= ny_s5;
		b01_s4 <= (p_s3[1] > p_s3[0]) ? p_s3[1] : p_s3[0];
		i01_s4 <= (p_s3[1] > p_s3[0]) ? 2'd1 : 2'd0;
		b23_s4 <= (p_s3[3] > p_s3[2]) ? p_s3[3] : p_s3[2];
		i23_s4 <= (p_s3[3] > p_s3[2]) ? 2'd3 : 2'd2;
		idx_s5 <= sel;
		dx_s5 <= cx_s4[sel];  dy_s5 <= cy_s4[sel];
		px_s5 <= cx_s4[selp]; py_s5 <= cy_s4[selp];
		qx_s5 <= cx_s4[seln]; qy_s5 <= cy_s4[seln];
		idx_s6 <= idx_s5;
		dx_s6 <= dx_s5; dy_s6 <= dy_s5; px_s6 <= px_s5; py_s6 <= py_s5;
		qx_s6 <= qx_s5; qy_s6 <= qy_s5;
		dpx_s6 <= dx_s5 - px_s5; dpy_s6 <= dy_s5 - py_s5;
		dnx_s6 <= dx_s5 - qx_s5; dny_s6 <= dy_s5 - qy_s5;
		sp_s7 <= reduce(dpx_s6, dpy_s6);
		sn_s7 <= reduce(dnx_s6, dny_s6);
		cr_s7 <= '{nx: nx_s6, ny: ny_s6, idx: idx_s6, deep_x: dx_s6, deep_y: dy_s6,
			prev_x: px_s6, prev_y: py_s6, next_x: qx_s6, next_y: qy_s6};
		cr_d[0] <= cr_s7;
		for (int k = 1; k < SIDE_LAT; k++) begin
			cr_d[k] <= cr_d[k-1];
		end
		cr_p1 <= cr_d[SIDE_LAT-1];
		m_px  <= upx * cr_d[SIDE_LAT-1].nx;
		m_py  <= upy * cr_d[SIDE_LAT-1].ny;
		m_nx  <= unx * cr_d[SIDE_LAT-1].nx;
		m_ny  <= uny * cr_d[SIDE_LAT-1].ny;
		cr_p2 <= cr_p1;
		dot_p <= m_px + m_py;
		dot_n <= m_nx + m_ny;
		deepest_index <= cr_p2.idx;
		deepest_x     <= cr_p2.deep_x;
		deepest_y     <= cr_p2.deep_y;
		if (dot_p <= dot_n) begin
			edge_start_x <= cr_p2.prev_x;
			edge_start_y <= cr_p2.prev_y;
			edge_end_x   <= cr_p2.deep_x;
			edge_end_y   <= cr_p2.deep_y;
		end else begin
			edge_start_x <= cr_p2.deep_x;
			edge_start_y <= cr_p2.deep_y;
			edge_end_x   <= cr_p2.next_x;
			edge_end_y   <= cr_p2.next_y;
		end
	end

	bbes_side_unit u_side_prev (
		.clk  (clk),
		.side (sp_s7),
		.ux   (upx),
		.uy   (upy)
	);

	bbes_side_unit u_side_next (
		.clk  (clk),
		.side (sn_s7),
		.ux   (unx),
		.uy   (uny)
	);

	assign busy = 1'b0;
	assign done = vld_q[TOTAL_LAT-1];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##TOTAL_LAT done)
		else $error("result missing after a transfer");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##TOTAL_LAT !done)
		else $error("result without a transfer");

	a_edge_touches_deepest: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((edge_end_x == deepest_x && edge_end_y == deepest_y) ||
			(edge_start_x == deepest_x && edge_start_y == deepest_y)))
		else $error("chosen edge does not meet the deepest corner");

endmodule

`default_nettype wire
